>>> sv/thp_pkg.sv
// ----------------------------------------------------------------------------
// thp_pkg
// shared types, codes and helpers of the thp compensation unit
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam logic [1:0] FUNC_TEMP  = 2'd0;
  localparam logic [1:0] FUNC_PRESS = 2'd1;
  localparam logic [1:0] FUNC_HUM   = 2'd2;

  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_HUM_A   = 3'd4;
  localparam logic [2:0] CFG_HUM_B   = 3'd5;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // signed divide by 2**k, truncating toward zero
  function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input logic [4:0] k);
    logic        [31:0] bias;
    logic signed [31:0] t;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    t    = $signed(x + bias);
    return 32'(t >>> k);
  endfunction

endpackage

>>> sv/sensor_thp_compensation_int32_unit.sv
// ----------------------------------------------------------------------------
// sensor_thp_compensation_int32_unit
// integer temperature / pressure / humidity compensation, shared multiplier
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o  func_i, raw_reading_i
//  out      output     out_valid_o / out_stall_i kind_o, value_o
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
//  temperature and humidity use only the multiplier; pressure also waits on the
//  divider, and a zero divisor cuts pressure short before the divider starts
//  one item at a time: in_stall_o is high from acceptance until the result
//  is taken; func code 3 is accepted and dropped at once
//  the result register holds while out_stall_i is high
//  reset clears the calibration registers and the fine temperature
// ----------------------------------------------------------------------------
module sensor_thp_compensation_int32_unit import thp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [19:0]        raw_reading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [17:0] value_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
    ST_P9, ST_P10, ST_PDIV, ST_P11, ST_P12, ST_P13, ST_P14,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // calibration registers
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q, cal_press_b_q;
  logic [15:0] cal_press_c_q;
  logic [31:0] cal_hum_a_q;
  logic [39:0] cal_hum_b_q;

  // working registers
  logic [1:0]  func_q, func_d;
  logic [19:0] raw_q, raw_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, q_q, q_d, p_q, p_d;
  logic [31:0] ft_q, ft_d;
  logic        hi_q, hi_d;
  logic [1:0]  kind_q, kind_d;
  logic [17:0] val_q, val_d;

  // shared units
  logic [31:0] mul_a, mul_b, prod;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // coefficients, sign- or zero-extended to 32 bits
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, cal_temp_q[15:0]};
  assign t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
  assign t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
  assign p1 = {16'd0, cal_press_a_q[15:0]};
  assign p2 = {{16{cal_press_a_q[31]}}, cal_press_a_q[31:16]};
  assign p3 = {{16{cal_press_a_q[47]}}, cal_press_a_q[47:32]};
  assign p4 = {{16{cal_press_a_q[63]}}, cal_press_a_q[63:48]};
  assign p5 = {{16{cal_press_b_q[15]}}, cal_press_b_q[15:0]};
  assign p6 = {{16{cal_press_b_q[31]}}, cal_press_b_q[31:16]};
  assign p7 = {{16{cal_press_b_q[47]}}, cal_press_b_q[47:32]};
  assign p8 = {{16{cal_press_b_q[63]}}, cal_press_b_q[63:48]};
  assign p9 = {{16{cal_press_c_q[15]}}, cal_press_c_q};
  assign h1 = {24'd0, cal_hum_a_q[7:0]};
  assign h2 = {{16{cal_hum_a_q[23]}}, cal_hum_a_q[23:8]};
  assign h3 = {24'd0, cal_hum_a_q[31:24]};
  assign h4 = {{16{cal_hum_b_q[15]}}, cal_hum_b_q[15:0]};
  assign h5 = {{16{cal_hum_b_q[31]}}, cal_hum_b_q[31:16]};
  assign h6 = {{24{cal_hum_b_q[39]}}, cal_hum_b_q[39:32]};

  thp_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  thp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    logic [31:0] x;
    logic [31:0] y;
    state_d = state_q;
    func_d  = func_q;
    raw_d   = raw_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; q_d = q_q; p_d = p_q;
    ft_d    = ft_q;
    hi_d    = hi_q;
    kind_d  = kind_q;
    val_d   = val_q;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    x       = '0;
    y       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          raw_d  = raw_reading_i;
          case (func_i)
            FUNC_TEMP:  state_d = ST_T0;
            FUNC_PRESS: state_d = ST_P0;
            FUNC_HUM:   state_d = ST_H0;
            default:    state_d = ST_IDLE;
          endcase
        end
      end

      // temperature
      ST_T0: begin
        a_d = {15'd0, raw_q[19:3]} - (t1 << 1);
        b_d = {16'd0, raw_q[19:4]} - t1;
        state_d = ST_T1;
      end
      ST_T1: begin
        mul_a = a_q; mul_b = t2;
        a_d = sdiv_p2(prod, 5'd11);
        state_d = ST_T2;
      end
      ST_T2: begin
        mul_a = b_q; mul_b = b_q;
        b_d = sdiv_p2(prod, 5'd12);
        state_d = ST_T3;
      end
      ST_T3: begin
        mul_a = b_q; mul_b = t3;
        b_d = sdiv_p2(prod, 5'd14);
        state_d = ST_T4;
      end
      ST_T4: begin
        ft_d = a_q + b_q;
        state_d = ST_T5;
      end
      ST_T5: begin
        mul_a = ft_q; mul_b = 32'd5;
        x = sdiv_p2(prod + 32'd128, 5'd8);
        if ($signed(x) < -32'sd4000) x = -32'sd4000;
        else if ($signed(x) > 32'sd8500) x = 32'sd8500;
        val_d   = x[17:0];
        kind_d  = func_q;
        state_d = ST_DONE;
      end

      // pressure
      ST_P0: begin
        a_d = sdiv_p2(ft_q, 5'd1) - 32'd64000;
        state_d = ST_P1;
      end
      ST_P1: begin
        mul_a = sdiv_p2(a_q, 5'd2); mul_b = sdiv_p2(a_q, 5'd2);
        q_d = prod;
        state_d = ST_P2;
      end
      ST_P2: begin
        mul_a = sdiv_p2(q_q, 5'd11); mul_b = p6;
        b_d = prod;
        state_d = ST_P3;
      end
      ST_P3: begin
        mul_a = a_q; mul_b = p5;
        b_d = b_q + (prod << 1);
        state_d = ST_P4;
      end
      ST_P4: begin
        b_d = sdiv_p2(b_q, 5'd2) + (p4 << 16);
        state_d = ST_P5;
      end
      ST_P5: begin
        mul_a = p3; mul_b = sdiv_p2(q_q, 5'd13);
        c_d = sdiv_p2(prod, 5'd3);
        state_d = ST_P6;
      end
      ST_P6: begin
        mul_a = p2; mul_b = a_q;
        d_d = sdiv_p2(prod, 5'd1);
        state_d = ST_P7;
      end
      ST_P7: begin
        a_d = sdiv_p2(c_q + d_q, 5'd18);
        state_d = ST_P8;
      end
      ST_P8: begin
        mul_a = 32'd32768 + a_q; mul_b = p1;
        x = sdiv_p2(prod, 5'd15);
        a_d = x;
        if (x == 32'd0) begin
          // zero divisor gives the minimum pressure
          val_d   = 18'd30000;
          kind_d  = func_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_P9;
        end
      end
      ST_P9: begin
        mul_a = 32'd1048576 - {12'd0, raw_q} - sdiv_p2(b_q, 5'd12);
        mul_b = 32'd3125;
        p_d = prod;
        state_d = ST_P10;
      end
      ST_P10: begin
        div_req.start    = 1'b1;
        div_req.dividend = p_q[31] ? p_q : (p_q << 1);
        div_req.divisor  = a_q;
        hi_d    = p_q[31];
        state_d = ST_PDIV;
      end
      ST_PDIV: begin
        if (div_rsp.done) begin
          p_d = hi_q ? (div_rsp.quotient << 1) : div_rsp.quotient;
          state_d = ST_P11;
        end
      end
      ST_P11: begin
        mul_a = p_q >> 3; mul_b = p_q >> 3;
        q_d = prod >> 13;
        state_d = ST_P12;
      end
      ST_P12: begin
        mul_a = p9; mul_b = q_q;
        a_d = sdiv_p2(prod, 5'd12);
        state_d = ST_P13;
      end
      ST_P13: begin
        mul_a = p_q >> 2; mul_b = p8;
        b_d = sdiv_p2(prod, 5'd13);
        state_d = ST_P14;
      end
      ST_P14: begin
        y = p_q + sdiv_p2(a_q + b_q + p7, 5'd4);
        // clamp as an unsigned number
        if (y < 32'd30000) y = 32'd30000;
        else if (y > 32'd110000) y = 32'd110000;
        val_d   = y[17:0];
        kind_d  = func_q;
        state_d = ST_DONE;
      end

      // humidity
      ST_H0: begin
        a_d = ft_q - 32'd76800;
        b_d = {2'd0, raw_q[15:0], 14'd0};
        state_d = ST_H1;
      end
      ST_H1: begin
        mul_a = h5; mul_b = a_q;
        c_d = sdiv_p2(b_q - (h4 << 20) - prod + 32'd16384, 5'd15);
        state_d = ST_H2;
      end
      ST_H2: begin
        mul_a = a_q; mul_b = h6;
        b_d = sdiv_p2(prod, 5'd10);
        state_d = ST_H3;
      end
      ST_H3: begin
        mul_a = a_q; mul_b = h3;
        d_d = sdiv_p2(prod, 5'd11);
        state_d = ST_H4;
      end
      ST_H4: begin
        mul_a = b_q; mul_b = d_q + 32'd32768;
        d_d = sdiv_p2(prod, 5'd10) + 32'd2097152;
        state_d = ST_H5;
      end
      ST_H5: begin
        mul_a = d_q; mul_b = h2;
        b_d = sdiv_p2(prod + 32'd8192, 5'd14);
        state_d = ST_H6;
      end
      ST_H6: begin
        mul_a = c_q; mul_b = b_q;
        c_d = prod;
        state_d = ST_H7;
      end
      ST_H7: begin
        mul_a = sdiv_p2(c_q, 5'd15); mul_b = sdiv_p2(c_q, 5'd15);
        d_d = sdiv_p2(prod, 5'd7);
        state_d = ST_H8;
      end
      ST_H8: begin
        mul_a = d_q; mul_b = h1;
        x = c_q - sdiv_p2(prod, 5'd4);
        if ($signed(x) < 32'sd0) x = 32'd0;
        if ($signed(x) > 32'sd419430400) x = 32'd419430400;
        x = x >> 12;
        if (x > 32'd102400) x = 32'd102400;
        val_d   = x[17:0];
        kind_d  = func_q;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ft_q          <= '0;
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_press_c_q <= '0;
      cal_hum_a_q   <= '0;
      cal_hum_b_q   <= '0;
    end else begin
      state_q <= state_d;
      ft_q    <= ft_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEMP:    cal_temp_q    <= cfg_data_i[47:0];
          CFG_PRESS_A: cal_press_a_q <= cfg_data_i;
          CFG_PRESS_B: cal_press_b_q <= cfg_data_i;
          CFG_PRESS_C: cal_press_c_q <= cfg_data_i[15:0];
          CFG_HUM_A:   cal_hum_a_q   <= cfg_data_i[31:0];
          CFG_HUM_B:   cal_hum_b_q   <= cfg_data_i[39:0];
          default:     ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    raw_q  <= raw_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    q_q    <= q_d;
    p_q    <= p_d;
    hi_q   <= hi_d;
    kind_q <= kind_d;
    val_q  <= val_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign kind_o      = kind_q;
  assign value_o     = $signed(val_q);

endmodule

>>> sv/thp_mul.sv
// ----------------------------------------------------------------------------
// thp_mul
// shared 32x32 multiplier, low word of the product (wraps at 32 bits)
// ----------------------------------------------------------------------------
module thp_mul import thp_pkg::*; (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  // low 32 bits are the same for signed and unsigned operands
  assign p_o = a_i * b_i;

endmodule

>>> sv/thp_div.sv
// ----------------------------------------------------------------------------
// thp_div
// restoring unsigned 32/32 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module thp_div import thp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] rem_sh;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[31:0], quo_q[31]};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> tb/sensor_thp_compensation_int32_unit_tb.sv
// ----------------------------------------------------------------------------
// sensor_thp_compensation_int32_unit_tb
// self-checking bench: a directed table of readings, then a typical table and
// random readings under several calibration sets, each result checked against a
// known answer or an own bit-accurate model of the integer compensation formulas
// ----------------------------------------------------------------------------
module sensor_thp_compensation_int32_unit_tb;
  import thp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [1:0]  FUNC_NONE   = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i = '0;
  logic [19:0]        raw_reading_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic signed [17:0] value_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [63:0]        cfg_data_i = '0;

  sensor_thp_compensation_int32_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // calibration shadow and fine temperature of the predictor
  logic [47:0] cal_t;
  logic [63:0] cal_pa, cal_pb;
  logic [15:0] cal_pc;
  logic [31:0] cal_ha;
  logic [39:0] cal_hb;
  int          t_fine;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [17:0] value;
    logic               fixed;
  } reading_t;

  reading_t pending_q[$];
  int       mismatches = 0;
  int       sender_idle = 0;
  int       receiver_idle = 0;
  bit       hold_receiver = 1'b0;
  int unsigned quiet_cycles = 0;

  // truncating signed division as in C
  function automatic int tdiv(int a, int b);
    return a / b;
  endfunction

  function automatic int s16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int temp_value(logic [19:0] raw);
    int t1, t2, t3, a, b, t;
    t1 = int'(cal_t[15:0]);
    t2 = s16(cal_t[31:16]);
    t3 = s16(cal_t[47:32]);
    a = int'(raw >> 3) - t1 * 2;
    a = tdiv(a * t2, 2048);
    b = int'(raw >> 4) - t1;
    b = tdiv(b * b, 4096);
    b = tdiv(b * t3, 16384);
    t_fine = a + b;
    t = tdiv(t_fine * 5 + 128, 256);
    if (t < -4000) t = -4000;
    else if (t > 8500) t = 8500;
    return t;
  endfunction

  function automatic int press_value(logic [19:0] raw);
    int p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, c, d, q;
    int unsigned p, pd;
    p1 = int'(cal_pa[15:0]);
    p2 = s16(cal_pa[31:16]);
    p3 = s16(cal_pa[47:32]);
    p4 = s16(cal_pa[63:48]);
    p5 = s16(cal_pb[15:0]);
    p6 = s16(cal_pb[31:16]);
    p7 = s16(cal_pb[47:32]);
    p8 = s16(cal_pb[63:48]);
    p9 = s16(cal_pc);
    a = tdiv(t_fine, 2) - 64000;
    q = tdiv(a, 4) * tdiv(a, 4);
    b = tdiv(q, 2048) * p6;
    b = b + (a * p5) * 2;
    b = tdiv(b, 4) + p4 * 65536;
    c = tdiv(p3 * tdiv(q, 8192), 8);
    d = tdiv(p2 * a, 2);
    a = tdiv(c + d, 262144);
    a = tdiv((32768 + a) * p1, 32768);
    if (a == 0) return 30000;
    p = (32'd1048576 - 32'(raw) - 32'(tdiv(b, 4096))) * 32'd3125;
    pd = 32'(a);
    if (p < 32'h8000_0000) p = (p << 1) / pd;
    else p = (p / pd) * 32'd2;
    pd = ((p >> 3) * (p >> 3)) >> 13;
    a = tdiv(p9 * int'(pd), 4096);
    b = tdiv(int'(p >> 2) * p8, 8192);
    c = tdiv(a + b + p7, 16);
    p = p + 32'(c);
    if (p < 32'd30000) p = 30000;
    else if (p > 32'd110000) p = 110000;
    return int'(p);
  endfunction

  function automatic int hum_value(logic [19:0] raw);
    int h1, h2, h3, h4, h5, h6, v1, v2, v3, v4, v5;
    h1 = int'(cal_ha[7:0]);
    h2 = s16(cal_ha[23:8]);
    h3 = int'(cal_ha[31:24]);
    h4 = s16(cal_hb[15:0]);
    h5 = s16(cal_hb[31:16]);
    h6 = int'($signed(cal_hb[39:32]));
    v1 = t_fine - 76800;
    v2 = int'({raw[15:0], 14'd0});
    v3 = h4 * 1048576;
    v4 = h5 * v1;
    v5 = tdiv(v2 - v3 - v4 + 16384, 32768);
    v2 = tdiv(v1 * h6, 1024);
    v3 = tdiv(v1 * h3, 2048);
    v4 = tdiv(v2 * (v3 + 32768), 1024) + 2097152;
    v2 = tdiv(v4 * h2 + 8192, 16384);
    v3 = v5 * v2;
    v4 = tdiv(tdiv(v3, 32768) * tdiv(v3, 32768), 128);
    v5 = v3 - tdiv(v4 * h1, 16);
    if (v5 < 0) v5 = 0;
    if (v5 > 419430400) v5 = 419430400;
    v5 = v5 / 4096;
    if (v5 > 102400) v5 = 102400;
    return v5;
  endfunction

  // expected compensation of one accepted reading, queued in order
  function automatic void predict_reading(logic [1:0] func, logic [19:0] raw);
    reading_t r;
    int v;
    case (func)
      FUNC_TEMP:  v = temp_value(raw);
      FUNC_PRESS: v = press_value(raw);
      FUNC_HUM:   v = hum_value(raw);
      default:    return;
    endcase
    r.kind = func;
    r.value = 18'(v);
    r.fixed = 1'b0;
    pending_q.push_back(r);
  endfunction

  task automatic write_cal(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_TEMP:    cal_t = data[47:0];
      CFG_PRESS_A: cal_pa = data;
      CFG_PRESS_B: cal_pb = data;
      CFG_PRESS_C: cal_pc = data[15:0];
      CFG_HUM_A:   cal_ha = data[31:0];
      CFG_HUM_B:   cal_hb = data[39:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one reading, hold it until accepted; optional known answer
  // valid stays high after acceptance so back-to-back items need no gap
  task automatic send_reading(logic [1:0] func, logic [19:0] raw,
                              bit known = 1'b0, int answer = 0);
    reading_t r;
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    if (known) begin
      r.kind = func;
      r.value = 18'(answer);
      r.fixed = 1'b1;
      if (func == FUNC_TEMP) void'(temp_value(raw));
      pending_q.push_back(r);
    end else begin
      predict_reading(func, raw);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    raw_reading_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  // receiver stall, long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_receiver) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < receiver_idle);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind %0d value %0d", kind_o, value_o);
        end else begin
          e = pending_q.pop_front();
          if (e.kind !== kind_o || e.value !== value_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind %0d value %0d, got kind %0d value %0d",
                       e.kind, e.value, kind_o, value_o);
          end
        end
      end
    end
  end

  typedef struct {
    logic [1:0]  func;
    logic [19:0] raw;
    bit          known;
    int          answer;
  } stim_row_t;

  stim_row_t directed[] = '{
    // all calibration zero after reset
    '{FUNC_TEMP,  20'h00000, 1'b1, 0},
    '{FUNC_PRESS, 20'h00000, 1'b1, 30000},  // zero divisor
    '{FUNC_HUM,   20'hFFFFF, 1'b1, 0},
    '{FUNC_NONE,  20'h12345, 1'b0, 0},      // unused code, no result
    '{FUNC_PRESS, 20'hFFFFF, 1'b1, 30000}
  };

  stim_row_t typical[] = '{
    '{FUNC_PRESS, 20'h65000, 1'b0, 0},      // pressure before temperature
    '{FUNC_TEMP,  20'h7E000, 1'b0, 0},
    '{FUNC_PRESS, 20'h65000, 1'b0, 0},
    '{FUNC_HUM,   20'h06A00, 1'b0, 0},
    '{FUNC_TEMP,  20'h00000, 1'b0, 0},
    '{FUNC_TEMP,  20'hFFFFF, 1'b0, 0},
    '{FUNC_PRESS, 20'h00000, 1'b0, 0},
    '{FUNC_PRESS, 20'hFFFFF, 1'b0, 0},
    '{FUNC_HUM,   20'h0FFFF, 1'b0, 0},
    '{FUNC_HUM,   20'hF0000, 1'b0, 0},
    '{FUNC_NONE,  20'hFFFFF, 1'b0, 0},
    '{FUNC_HUM,   20'h00000, 1'b0, 0}
  };

  // random calibration: typical datasheet-like, extremes, or fully random
  task automatic load_cal(int mode);
    logic [63:0] w [6];
    if (mode == 0) begin
      w[0] = {16'sd50, 16'sd26435, 16'd27504};
      w[1] = {16'sd2855, -16'sd10685, 16'(-16'sd10685 + 16'sd0), 16'd36477};
      w[1] = {16'sd2855, 16'(-16'sd10685), 16'(16'sd3024), 16'd36477};
      w[2] = {16'sd15500, 16'(-16'sd14600), 16'(-16'sd7), 16'sd140};
      w[3] = 64'd6000;
      w[4] = {8'd0, 16'sd361, 8'd75};
      w[5] = {8'sd30, 16'sd50, 16'sd333};
      for (int i = 0; i < 6; i++) w[i] ^= 64'($urandom_range(63));
    end else if (mode == 1) begin
      for (int i = 0; i < 6; i++) w[i] = '1;
    end else if (mode == 2) begin
      w[0] = 64'h7FFF_8000_FFFF;
      w[1] = 64'h8000_7FFF_8000_0001;
      w[2] = 64'h7FFF_8000_7FFF_8000;
      w[3] = 64'h8000;
      w[4] = 64'h7F_8000_FF ^ 64'hFF00_0000;
      w[5] = 64'h80_7FFF_8000;
    end else begin
      for (int i = 0; i < 6; i++) w[i] = {$urandom, $urandom};
    end
    for (int i = 0; i < 6; i++) write_cal(3'(i), w[i]);
  endtask

  task automatic random_phase(int count, int cal_mode);
    logic [1:0]  f;
    logic [19:0] raw;
    load_cal(cal_mode);
    for (int i = 0; i < count; i++) begin
      f = 2'($urandom_range(2));
      if ($urandom_range(19) == 0) f = FUNC_NONE;
      case ($urandom_range(5))
        0: raw = '0;
        1: raw = '1;
        default: raw = (cal_mode == 0) ? 20'($urandom_range(20'hA0000, 20'h40000))
                                       : 20'($urandom);
      endcase
      send_reading(f, raw);
    end
    drain_wait();
  endtask

  initial begin
    cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_ha = '0; cal_hb = '0;
    t_fine = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i])
      send_reading(directed[i].func, directed[i].raw, directed[i].known, directed[i].answer);
    drain_wait();
    load_cal(0);
    foreach (typical[i]) send_reading(typical[i].func, typical[i].raw);
    drain_wait();

    // sender idles before a reading with odds of 20 in 100, receiver stalls with 82
    sender_idle = 20;
    receiver_idle = 82;
    random_phase(120, 0);
    random_phase(60, 1);

    // long receiver hold-off while readings keep coming
    fork
      begin
        hold_receiver = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_receiver = 1'b0;
      end
      for (int i = 0; i < 4; i++) send_reading(FUNC_TEMP, 20'($urandom));
    join
    drain_wait();

    sender_idle = 82;
    receiver_idle = 20;
    random_phase(120, 2);
    random_phase(100, 3);

    sender_idle = 0;
    receiver_idle = 0;
    random_phase(200, 0);
    random_phase(80, 3);

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
